### sv/qte_pkg.sv
`timescale 1ns / 1ps
// qte_pkg: shared types, constants and helper functions of the quaternion to
// Euler angle core. No dependencies.
package qte_pkg;

    localparam int PART_W    = 32;   // Q30 part width
    localparam int ACC_W     = 64;   // Q60 accumulator
    localparam int RAD_W     = 61;   // square root radicand, at most 2^60
    localparam int ROOT_W    = 31;   // root, at most 2^30
    localparam int REM_W     = 62;   // square root partial root register
    localparam int OPND_W    = 34;   // atan2 operand width
    localparam int VEC_W     = 38;   // CORDIC vector width, gain headroom
    localparam int ANG_W     = 22;   // angle in 1/4096 degree
    localparam int STEPS     = 16;
    localparam int STEP_W    = 4;
    localparam int DIG_W     = 4;    // multiplier digit
    localparam int MUL_DIGS  = PART_W / DIG_W;
    localparam int MCNT_W    = 3;
    localparam int PC_W      = 5;
    localparam int ACCY_W    = 16;
    localparam int DEG_W     = 16;
    localparam int PITCH_W   = 15;
    localparam int Q_SHIFT   = 29;

    localparam logic signed [PART_W-1:0] ONE_Q30   = 32'sd1073741824;
    localparam logic signed [OPND_W-1:0] ONE_Q30_O = 34'sd1073741824;
    localparam logic signed [ACC_W-1:0]  ONE_Q30_A = 64'sd1073741824;
    localparam logic signed [ACC_W-1:0]  ONE_Q60_A = 64'sd1152921504606846976;
    localparam logic [RAD_W-1:0]         ONE_Q60_R = 61'h1000000000000000;
    localparam logic signed [ANG_W-1:0]  ANG_90    = 22'sd368640;
    localparam logic signed [ANG_W-1:0]  ROLL_LIM  = 22'sd23040;
    localparam logic signed [ANG_W-1:0]  PITCH_LIM = 22'sd11520;
    localparam logic signed [DEG_W:0]    HEAD_OFS  = 17'sd23040;

    localparam logic [PC_W-1:0] PC_UPDATE = 5'd0;
    localparam logic [PC_W-1:0] PC_ITEM   = 5'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        K_MUL,      // acc (+/-)= a * b
        K_WSQRT,    // w = isqrt(max(1 - acc, 0))
        K_NUM,      // atan2 y operand from acc
        K_DEN,      // atan2 x operand, 1 - acc
        K_SSAT,     // pitch sine, saturated
        K_PSQRT,    // pitch cosine = isqrt(1 - acc)
        K_CORD,     // atan2
        K_DONE
    } t_kind;

    typedef enum logic [2:0] {
        OP_X,
        OP_Y,
        OP_Z,
        OP_W,
        OP_S
    } t_opsel;

    typedef enum logic [1:0] {
        D_ROLL,
        D_PITCH,
        D_YAW
    } t_dst;

    typedef struct packed {
        t_kind  kind;
        t_opsel a;
        t_opsel b;
        logic   first;
        logic   neg;
        t_dst   dst;
    } t_uop;

    typedef struct packed {
        logic start;
        logic first;
        logic neg;
    } t_mul_ctl;

    function automatic t_uop mk(input t_kind k, input t_opsel a, input t_opsel b,
                                input logic f, input logic n, input t_dst d);
        t_uop u;
        u.kind  = k;
        u.a     = a;
        u.b     = b;
        u.first = f;
        u.neg   = n;
        u.dst   = d;
        return u;
    endfunction

    // Micro-program. Items without an update start at PC_ITEM.
    function automatic t_uop prog(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(K_MUL,   OP_X, OP_X, 1'b1, 1'b0, D_ROLL);
            5'd1:    u = mk(K_MUL,   OP_Y, OP_Y, 1'b0, 1'b0, D_ROLL);
            5'd2:    u = mk(K_MUL,   OP_Z, OP_Z, 1'b0, 1'b0, D_ROLL);
            5'd3:    u = mk(K_WSQRT, OP_X, OP_X, 1'b0, 1'b0, D_ROLL);
            5'd4:    u = mk(K_MUL,   OP_W, OP_X, 1'b1, 1'b0, D_ROLL);
            5'd5:    u = mk(K_MUL,   OP_Y, OP_Z, 1'b0, 1'b0, D_ROLL);
            5'd6:    u = mk(K_NUM,   OP_X, OP_X, 1'b0, 1'b0, D_ROLL);
            5'd7:    u = mk(K_MUL,   OP_X, OP_X, 1'b1, 1'b0, D_ROLL);
            5'd8:    u = mk(K_MUL,   OP_Y, OP_Y, 1'b0, 1'b0, D_ROLL);
            5'd9:    u = mk(K_DEN,   OP_X, OP_X, 1'b0, 1'b0, D_ROLL);
            5'd10:   u = mk(K_CORD,  OP_X, OP_X, 1'b0, 1'b0, D_ROLL);
            5'd11:   u = mk(K_MUL,   OP_W, OP_Y, 1'b1, 1'b0, D_PITCH);
            5'd12:   u = mk(K_MUL,   OP_X, OP_Z, 1'b0, 1'b1, D_PITCH);
            5'd13:   u = mk(K_SSAT,  OP_X, OP_X, 1'b0, 1'b0, D_PITCH);
            5'd14:   u = mk(K_MUL,   OP_S, OP_S, 1'b1, 1'b0, D_PITCH);
            5'd15:   u = mk(K_PSQRT, OP_X, OP_X, 1'b0, 1'b0, D_PITCH);
            5'd16:   u = mk(K_CORD,  OP_X, OP_X, 1'b0, 1'b0, D_PITCH);
            5'd17:   u = mk(K_MUL,   OP_W, OP_Z, 1'b1, 1'b0, D_YAW);
            5'd18:   u = mk(K_MUL,   OP_X, OP_Y, 1'b0, 1'b0, D_YAW);
            5'd19:   u = mk(K_NUM,   OP_X, OP_X, 1'b0, 1'b0, D_YAW);
            5'd20:   u = mk(K_MUL,   OP_Y, OP_Y, 1'b1, 1'b0, D_YAW);
            5'd21:   u = mk(K_MUL,   OP_Z, OP_Z, 1'b0, 1'b0, D_YAW);
            5'd22:   u = mk(K_DEN,   OP_X, OP_X, 1'b0, 1'b0, D_YAW);
            5'd23:   u = mk(K_CORD,  OP_X, OP_X, 1'b0, 1'b0, D_YAW);
            default: u = mk(K_DONE,  OP_X, OP_X, 1'b0, 1'b0, D_ROLL);
        endcase
        return u;
    endfunction

    // atan(2^-i) in 1/4096 degree
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            4'd0:    a = 22'sd184320;
            4'd1:    a = 22'sd108810;
            4'd2:    a = 22'sd57492;
            4'd3:    a = 22'sd29184;
            4'd4:    a = 22'sd14649;
            4'd5:    a = 22'sd7331;
            4'd6:    a = 22'sd3667;
            4'd7:    a = 22'sd1833;
            4'd8:    a = 22'sd917;
            4'd9:    a = 22'sd458;
            4'd10:   a = 22'sd229;
            4'd11:   a = 22'sd115;
            4'd12:   a = 22'sd57;
            4'd13:   a = 22'sd29;
            4'd14:   a = 22'sd14;
            4'd15:   a = 22'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [PART_W-1:0] sat_part(input logic signed [PART_W-1:0] v);
        if (v > ONE_Q30) begin
            return ONE_Q30;
        end else if (v < -ONE_Q30) begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    // 1/4096 degree to 1/128 degree, rounded, then clamped to +-lim
    function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [ANG_W-1:0] a,
                                                        input logic signed [ANG_W-1:0] lim);
        logic signed [ANG_W-1:0] s;
        logic signed [ANG_W-1:0] t;
        s = a + 22'sd16;
        t = s >>> 5;
        if (t > lim) begin
            t = lim;
        end else if (t < -lim) begin
            t = -lim;
        end
        return t[DEG_W-1:0];
    endfunction

endpackage

### sv/qte_if.sv
`timescale 1ns / 1ps
// qte_in_if / qte_out_if: valid-ready request and result channels of the core.
// Depends on qte_pkg for widths.
interface qte_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   read_ok;
    logic                                   has_quat9;
    logic signed [qte_pkg::PART_W-1:0]      q_x;
    logic signed [qte_pkg::PART_W-1:0]      q_y;
    logic signed [qte_pkg::PART_W-1:0]      q_z;
    logic signed [qte_pkg::ACCY_W-1:0]      accuracy_in;

    modport source(output valid, read_ok, has_quat9, q_x, q_y, q_z, accuracy_in,
                   input ready);
    modport sink(input valid, read_ok, has_quat9, q_x, q_y, q_z, accuracy_in,
                 output ready);
endinterface

interface qte_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [qte_pkg::DEG_W-1:0]       roll_deg;
    logic signed [qte_pkg::PITCH_W-1:0]     pitch_deg;
    logic [qte_pkg::DEG_W-1:0]              heading_deg;
    logic signed [qte_pkg::ACCY_W-1:0]      accuracy_out;

    modport source(output valid, roll_deg, pitch_deg, heading_deg, accuracy_out,
                   input ready);
    modport sink(input valid, roll_deg, pitch_deg, heading_deg, accuracy_out,
                 output ready);
endinterface

### sv/qte_mul.sv
`timescale 1ns / 1ps
// qte_mul: digit-serial signed multiply-accumulate, 4 multiplier bits a cycle.
// Depends on qte_pkg.
module qte_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qte_pkg::t_mul_ctl                  i_ctl,
    input  logic signed [qte_pkg::PART_W-1:0]  i_a,
    input  logic signed [qte_pkg::PART_W-1:0]  i_b,
    output logic signed [qte_pkg::ACC_W-1:0]   o_acc,
    output logic                               o_done
);
    logic signed [qte_pkg::ACC_W-1:0]        r_ma;   // multiplicand, shifts left
    logic [qte_pkg::PART_W-1:0]              r_mb;   // multiplier, shifts right
    logic [qte_pkg::MCNT_W-1:0]              r_cnt;
    logic                                    r_busy;
    logic                                    r_done;
    logic                                    r_neg;
    logic signed [qte_pkg::ACC_W-1:0]        r_acc;
    logic signed [qte_pkg::DIG_W:0]          w_dig;
    logic signed [qte_pkg::ACC_W+qte_pkg::DIG_W:0] w_prod;
    logic signed [qte_pkg::ACC_W-1:0]        w_term;
    logic                                    w_last;

    assign w_last = (r_cnt == qte_pkg::MCNT_W'(qte_pkg::MUL_DIGS - 1));
    // top digit carries the sign of the multiplier
    assign w_dig  = w_last ? {r_mb[qte_pkg::DIG_W-1], r_mb[qte_pkg::DIG_W-1:0]}
                           : {1'b0, r_mb[qte_pkg::DIG_W-1:0]};
    assign w_prod = r_ma * w_dig;
    assign w_term = w_prod[qte_pkg::ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ma  <= qte_pkg::ACC_W'(i_a);
            r_mb  <= i_b;
            r_neg <= i_ctl.neg;
            if (i_ctl.first) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_ma  <= r_ma <<< qte_pkg::DIG_W;
            r_mb  <= r_mb >> qte_pkg::DIG_W;
            r_acc <= r_neg ? (r_acc - w_term) : (r_acc + w_term);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;
endmodule

### sv/qte_isqrt.sv
`timescale 1ns / 1ps
// qte_isqrt: floor integer square root, one result bit a cycle.
// Depends on qte_pkg.
module qte_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [qte_pkg::RAD_W-1:0]     i_rad,
    output logic [qte_pkg::ROOT_W-1:0]    o_root,
    output logic                          o_done
);
    logic [qte_pkg::RAD_W-1:0]  r_n;
    logic [qte_pkg::REM_W-1:0]  r_r;
    logic [qte_pkg::RAD_W-1:0]  r_b;    // one-hot, walks down two bits a step
    logic                       r_busy;
    logic                       r_done;
    logic [qte_pkg::REM_W-1:0]  w_sum;
    logic                       w_ge;
    logic                       w_last;

    assign w_sum  = r_r + qte_pkg::REM_W'(r_b);
    assign w_ge   = qte_pkg::REM_W'(r_n) >= w_sum;
    assign w_last = r_b[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_rad;
            r_r <= '0;
            r_b <= {1'b1, {(qte_pkg::RAD_W-1){1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_n <= r_n - w_sum[qte_pkg::RAD_W-1:0];
                r_r <= (r_r >> 1) + qte_pkg::REM_W'(r_b);
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_root = r_r[qte_pkg::ROOT_W-1:0];
    assign o_done = r_done;
endmodule

### sv/qte_cordic.sv
`timescale 1ns / 1ps
// qte_cordic: vectoring CORDIC atan2, one micro-rotation a cycle.
// Depends on qte_pkg.
module qte_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [qte_pkg::OPND_W-1:0]  i_x,
    input  logic signed [qte_pkg::OPND_W-1:0]  i_y,
    output logic signed [qte_pkg::ANG_W-1:0]   o_ang,
    output logic                               o_done
);
    logic signed [qte_pkg::VEC_W-1:0]  r_x;
    logic signed [qte_pkg::VEC_W-1:0]  r_y;
    logic signed [qte_pkg::ANG_W-1:0]  r_z;
    logic [qte_pkg::STEP_W-1:0]        r_i;
    logic                              r_zero;
    logic                              r_busy;
    logic                              r_done;
    logic signed [qte_pkg::VEC_W-1:0]  w_x0;
    logic signed [qte_pkg::VEC_W-1:0]  w_y0;
    logic signed [qte_pkg::VEC_W-1:0]  w_dx;
    logic signed [qte_pkg::VEC_W-1:0]  w_dy;
    logic                              w_last;

    assign w_x0   = qte_pkg::VEC_W'(i_x);
    assign w_y0   = qte_pkg::VEC_W'(i_y);
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_last = (r_i == qte_pkg::STEP_W'(qte_pkg::STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            // left half plane: pre-rotate by a quarter turn
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_z <= qte_pkg::ANG_90;
                    r_x <= w_y0;
                    r_y <= -w_x0;
                end else begin
                    r_z <= -qte_pkg::ANG_90;
                    r_x <= -w_y0;
                    r_y <= w_x0;
                end
            end else begin
                r_z <= '0;
                r_x <= w_x0;
                r_y <= w_y0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + qte_pkg::atan_step(r_i);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - qte_pkg::atan_step(r_i);
            end
        end
    end

    assign o_ang  = r_zero ? '0 : r_z;
    assign o_done = r_done;
endmodule

### sv/quaternion_to_euler_angles_core.sv
`timescale 1ns / 1ps
// Quaternion to roll / pitch / heading core, one request at a time.
// The time per request is set by the 4-bit digit-serial multiplier (11 products, 14
// when the request updates the quaternion), the bit-serial square root and the 16-step
// CORDIC (x3). Reset (synchronous, active low) clears the stored quaternion.
module quaternion_to_euler_angles_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qte_in_if.sink       i_req,
    qte_out_if.source    o_rsp
);
    // Stored quaternion, already saturated to +-1.0 in Q30.
    logic signed [qte_pkg::PART_W-1:0]   r_px;
    logic signed [qte_pkg::PART_W-1:0]   r_py;
    logic signed [qte_pkg::PART_W-1:0]   r_pz;
    logic [qte_pkg::ROOT_W-1:0]          r_w;
    logic signed [qte_pkg::ACCY_W-1:0]   r_accy;

    // Sequencer
    qte_pkg::t_state                     r_state;
    qte_pkg::t_state                     n_state;
    logic [qte_pkg::PC_W-1:0]            r_pc;
    logic [qte_pkg::PC_W-1:0]            n_pc;
    qte_pkg::t_uop                       w_uop;

    // Working values
    logic signed [qte_pkg::PART_W-1:0]   r_s;    // pitch sine, Q30
    logic signed [qte_pkg::OPND_W-1:0]   r_cx;   // atan2 x
    logic signed [qte_pkg::OPND_W-1:0]   r_cy;   // atan2 y
    logic signed [qte_pkg::DEG_W-1:0]    r_roll;
    logic signed [qte_pkg::PITCH_W-1:0]  r_pitch;
    logic [qte_pkg::DEG_W-1:0]           r_head;

    // Output register
    logic                                r_ov;
    logic signed [qte_pkg::DEG_W-1:0]    r_o_roll;
    logic signed [qte_pkg::PITCH_W-1:0]  r_o_pitch;
    logic [qte_pkg::DEG_W-1:0]           r_o_head;
    logic signed [qte_pkg::ACCY_W-1:0]   r_o_accy;

    // Unit hookup
    qte_pkg::t_mul_ctl                   w_mul_ctl;
    logic signed [qte_pkg::PART_W-1:0]   w_opa;
    logic signed [qte_pkg::PART_W-1:0]   w_opb;
    logic signed [qte_pkg::ACC_W-1:0]    w_acc;
    logic signed [qte_pkg::ACC_W-1:0]    w_acc_sh;
    logic                                w_mul_done;
    logic                                w_sqrt_start;
    logic [qte_pkg::RAD_W-1:0]           w_rad;
    logic [qte_pkg::ROOT_W-1:0]          w_root;
    logic                                w_sqrt_done;
    logic                                w_cord_start;
    logic signed [qte_pkg::ANG_W-1:0]    w_ang;
    logic                                w_cord_done;
    logic                                w_unit_done;
    logic                                w_accept;
    logic                                w_update;
    logic                                w_out_free;
    logic signed [qte_pkg::DEG_W-1:0]    w_deg;
    logic signed [qte_pkg::DEG_W:0]      w_head;

    assign w_uop      = qte_pkg::prog(r_pc);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_update   = i_req.read_ok && i_req.has_quat9;
    assign w_out_free = !r_ov || o_rsp.ready;
    assign w_acc_sh   = w_acc >>> qte_pkg::Q_SHIFT;

    function automatic logic signed [qte_pkg::PART_W-1:0] opnd(input qte_pkg::t_opsel s,
        input logic signed [qte_pkg::PART_W-1:0] x, input logic signed [qte_pkg::PART_W-1:0] y,
        input logic signed [qte_pkg::PART_W-1:0] z, input logic [qte_pkg::ROOT_W-1:0] w,
        input logic signed [qte_pkg::PART_W-1:0] sn);
        logic signed [qte_pkg::PART_W-1:0] v;
        case (s)
            qte_pkg::OP_X: v = x;
            qte_pkg::OP_Y: v = y;
            qte_pkg::OP_Z: v = z;
            qte_pkg::OP_W: v = {1'b0, w};
            qte_pkg::OP_S: v = sn;
            default:       v = '0;
        endcase
        return v;
    endfunction

    assign w_opa = opnd(w_uop.a, r_px, r_py, r_pz, r_w, r_s);
    assign w_opb = opnd(w_uop.b, r_px, r_py, r_pz, r_w, r_s);

    // w radicand: 1 - (x^2+y^2+z^2) clamped at zero; pitch radicand: 1 - s^2
    always_comb begin
        if (w_uop.kind == qte_pkg::K_WSQRT) begin
            w_rad = (w_acc < qte_pkg::ONE_Q60_A)
                  ? (qte_pkg::ONE_Q60_R - w_acc[qte_pkg::RAD_W-1:0]) : '0;
        end else begin
            w_rad = qte_pkg::ONE_Q60_R - w_acc[qte_pkg::RAD_W-1:0];
        end
    end

    always_comb begin
        case (w_uop.kind)
            qte_pkg::K_MUL:   w_unit_done = w_mul_done;
            qte_pkg::K_WSQRT: w_unit_done = w_sqrt_done;
            qte_pkg::K_PSQRT: w_unit_done = w_sqrt_done;
            default:          w_unit_done = w_cord_done;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qte_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = qte_pkg::ST_ISSUE;
                end
            end
            qte_pkg::ST_ISSUE: begin
                case (w_uop.kind)
                    qte_pkg::K_MUL, qte_pkg::K_WSQRT, qte_pkg::K_PSQRT,
                    qte_pkg::K_CORD: n_state = qte_pkg::ST_WAIT;
                    qte_pkg::K_DONE: n_state = qte_pkg::ST_OUT;
                    default:         n_state = qte_pkg::ST_ISSUE;
                endcase
            end
            qte_pkg::ST_WAIT: begin
                if (w_unit_done) begin
                    n_state = qte_pkg::ST_ISSUE;
                end
            end
            qte_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = qte_pkg::ST_IDLE;
                end
            end
            default: n_state = qte_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready     = 1'b0;
        w_mul_ctl       = '0;
        w_sqrt_start    = 1'b0;
        w_cord_start    = 1'b0;
        n_pc            = r_pc;
        case (r_state)
            qte_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_pc = w_update ? qte_pkg::PC_UPDATE : qte_pkg::PC_ITEM;
                end
            end
            qte_pkg::ST_ISSUE: begin
                case (w_uop.kind)
                    qte_pkg::K_MUL: begin
                        w_mul_ctl.start = 1'b1;
                        w_mul_ctl.first = w_uop.first;
                        w_mul_ctl.neg   = w_uop.neg;
                    end
                    qte_pkg::K_WSQRT, qte_pkg::K_PSQRT: w_sqrt_start = 1'b1;
                    qte_pkg::K_CORD:                    w_cord_start = 1'b1;
                    qte_pkg::K_NUM, qte_pkg::K_DEN,
                    qte_pkg::K_SSAT:                    n_pc = r_pc + 1'b1;
                    default: ;
                endcase
            end
            qte_pkg::ST_WAIT: begin
                if (w_unit_done) begin
                    n_pc = r_pc + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qte_pkg::ST_IDLE;
            r_pc    <= '0;
            r_ov    <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_w     <= '0;
            r_accy  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (w_accept && w_update) begin
                r_px   <= qte_pkg::sat_part(i_req.q_x);
                r_py   <= qte_pkg::sat_part(i_req.q_y);
                r_pz   <= qte_pkg::sat_part(i_req.q_z);
                r_accy <= i_req.accuracy_in;
            end
            if (r_state == qte_pkg::ST_WAIT && w_sqrt_done &&
                w_uop.kind == qte_pkg::K_WSQRT) begin
                r_w <= w_root;
            end
            if (r_state == qte_pkg::ST_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign w_deg  = qte_pkg::to_deg(w_ang, (w_uop.dst == qte_pkg::D_PITCH)
                                           ? qte_pkg::PITCH_LIM : qte_pkg::ROLL_LIM);
    assign w_head = qte_pkg::HEAD_OFS - (qte_pkg::DEG_W+1)'(w_deg);

    // Working datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == qte_pkg::ST_ISSUE) begin
            case (w_uop.kind)
                qte_pkg::K_NUM: r_cy <= w_acc_sh[qte_pkg::OPND_W-1:0];
                qte_pkg::K_DEN: r_cx <= qte_pkg::ONE_Q30_O - w_acc_sh[qte_pkg::OPND_W-1:0];
                qte_pkg::K_SSAT: begin
                    if (w_acc_sh > qte_pkg::ONE_Q30_A) begin
                        r_s  <= qte_pkg::ONE_Q30;
                        r_cy <= qte_pkg::ONE_Q30_O;
                    end else if (w_acc_sh < -qte_pkg::ONE_Q30_A) begin
                        r_s  <= -qte_pkg::ONE_Q30;
                        r_cy <= -qte_pkg::ONE_Q30_O;
                    end else begin
                        r_s  <= w_acc_sh[qte_pkg::PART_W-1:0];
                        r_cy <= w_acc_sh[qte_pkg::OPND_W-1:0];
                    end
                end
                default: ;
            endcase
        end
        if (r_state == qte_pkg::ST_WAIT && w_unit_done) begin
            case (w_uop.kind)
                qte_pkg::K_PSQRT: r_cx <= qte_pkg::OPND_W'(w_root);
                qte_pkg::K_CORD: begin
                    case (w_uop.dst)
                        qte_pkg::D_ROLL:  r_roll  <= w_deg;
                        qte_pkg::D_PITCH: r_pitch <= w_deg[qte_pkg::PITCH_W-1:0];
                        default:          r_head  <= w_head[qte_pkg::DEG_W-1:0];
                    endcase
                end
                default: ;
            endcase
        end
        if (r_state == qte_pkg::ST_OUT && w_out_free) begin
            r_o_roll  <= r_roll;
            r_o_pitch <= r_pitch;
            r_o_head  <= r_head;
            r_o_accy  <= r_accy;
        end
    end

    qte_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_acc   (w_acc),
        .o_done  (w_mul_done)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_rad),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    qte_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .o_ang   (w_ang),
        .o_done  (w_cord_done)
    );

    assign o_rsp.valid        = r_ov;
    assign o_rsp.roll_deg     = r_o_roll;
    assign o_rsp.pitch_deg    = r_o_pitch;
    assign o_rsp.heading_deg  = r_o_head;
    assign o_rsp.accuracy_out = r_o_accy;
endmodule

### sv/qte_chk.sv
`timescale 1ns / 1ps
// qte_chk: port-level checks of the core, bound to the top level.
// Depends on qte_pkg widths only.
module qte_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [qte_pkg::DEG_W-1:0]    i_roll,
    input  logic signed [qte_pkg::PITCH_W-1:0]  i_pitch,
    input  logic [qte_pkg::DEG_W-1:0]           i_head
);
    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one request at a time: ready drops after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("request taken while busy");

    // angles stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roll >= -16'sd23040) && (i_roll <= 16'sd23040) &&
                        (i_pitch >= -15'sd11520) && (i_pitch <= 15'sd11520) &&
                        (i_head <= 16'd46080))
        else $error("angle out of range");

    // a fresh result does not appear right after a request is taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared right after request");
endmodule

bind quaternion_to_euler_angles_core qte_chk u_qte_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_roll      (o_rsp.roll_deg),
    .i_pitch     (o_rsp.pitch_deg),
    .i_head      (o_rsp.heading_deg)
);

### test/qte_tb_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the quaternion to Euler angle core: a bit-exact angle
// predictor and the queue of expected results.
class qte_angle_board;
    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic [15:0]        heading;
        logic signed [15:0] accy;
    } t_angles;

    logic [31:0]        sx, sy, sz;
    logic [30:0]        sw;
    logic signed [15:0] sacc;
    t_angles            pending[$];
    int                 errors;
    int                 checked;
    int                 updates;

    function new();
        sx = '0; sy = '0; sz = '0; sw = '0; sacc = '0;
        errors = 0; checked = 0; updates = 0;
    endfunction

    static function longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    static function longint unsigned root60(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, result in 1/4096 degree
    static function longint vec_angle(longint ay, longint ax);
        longint zacc, t, dx, dy;
        longint steps[16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667,
                              1833, 917, 458, 229, 115, 57, 29, 14, 7};
        zacc = 0;
        if (ax == 0 && ay == 0) return 0;
        if (ax < 0) begin
            if (ay >= 0) begin
                zacc = 368640; t = ax; ax = ay; ay = -t;
            end else begin
                zacc = -368640; t = ax; ax = -ay; ay = t;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (ay > 0) begin
                ax += dx; ay -= dy; zacc += steps[i];
            end else begin
                ax -= dx; ay += dy; zacc -= steps[i];
            end
        end
        return zacc;
    endfunction

    static function longint deg128(longint a, longint lim);
        return clip((a + 16) >>> 5, lim);
    endfunction

    function void note_request(logic rok, logic q9, logic [31:0] qx, logic [31:0] qy,
                               logic [31:0] qz, logic [15:0] acc);
        longint x, y, z, w, s, c;
        longint unsigned sq;
        t_angles e;
        if (rok && q9) begin
            sx = qx; sy = qy; sz = qz; sacc = acc;
            x = clip(longint'($signed(qx)), 64'sd1 << 30);
            y = clip(longint'($signed(qy)), 64'sd1 << 30);
            z = clip(longint'($signed(qz)), 64'sd1 << 30);
            sq = x * x + y * y + z * z;
            sw = 31'(root60((64'd1 << 60) > sq ? (64'd1 << 60) - sq : 64'd0));
            updates++;
        end
        x = clip(longint'($signed(sx)), 64'sd1 << 30);
        y = clip(longint'($signed(sy)), 64'sd1 << 30);
        z = clip(longint'($signed(sz)), 64'sd1 << 30);
        w = longint'({33'd0, sw});
        e.roll = 16'(deg128(vec_angle((w * x + y * z) >>> 29,
                                      (64'sd1 << 30) - ((x * x + y * y) >>> 29)), 23040));
        s = clip((w * y - x * z) >>> 29, 64'sd1 << 30);
        c = root60((64'd1 << 60) - s * s);
        e.pitch = 15'(deg128(vec_angle(s, c), 11520));
        e.heading = 16'(23040 - deg128(vec_angle((w * z + x * y) >>> 29,
                                       (64'sd1 << 30) - ((y * y + z * z) >>> 29)), 23040));
        e.accy = sacc;
        pending.push_back(e);
    endfunction

    function void check_result(logic [15:0] roll, logic [14:0] pitch, logic [15:0] head,
                               logic [15:0] accy);
        t_angles e;
        if (pending.size() == 0) begin
            $error("unexpected result roll=%0d", $signed(roll));
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (roll !== e.roll) begin
            $error("roll_deg: expected %0d actual %0d", e.roll, $signed(roll));
            errors++;
        end
        if (pitch !== e.pitch) begin
            $error("pitch_deg: expected %0d actual %0d", e.pitch, $signed(pitch));
            errors++;
        end
        if (head !== e.heading) begin
            $error("heading_deg: expected %0d actual %0d", e.heading, head);
            errors++;
        end
        if (accy !== e.accy) begin
            $error("accuracy_out: expected %0d actual %0d", e.accy, $signed(accy));
            errors++;
        end
    endfunction
endclass

### test/tb_quaternion_to_euler_angles_core.sv
`timescale 1ns / 1ps
// Testbench top for quaternion_to_euler_angles_core: directed and random
// IMU reports with random idling on both sides. Depends on the core, qte_if and board.
module tb_quaternion_to_euler_angles_core;

    localparam int RANDOM_REQS = 1150;
    localparam longint CYCLE_LIMIT = 64'd3000000;
    localparam int ONE = 1073741824;

    logic   i_clk;
    logic   i_rst_n;
    longint cycles;
    int     hold_cycles;    // receiver hold-off counter
    bit     held_once;      // the long hold-off happens only once
    int     quiet_lo, quiet_hi;

    qte_in_if  req_ch();
    qte_out_if rsp_ch();
    qte_angle_board board;

    quaternion_to_euler_angles_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // idling is suppressed while the request count lies in [quiet_lo, quiet_hi)
    function automatic bit idle_now(int n);
        if (n >= quiet_lo && n < quiet_hi) return 1'b0;
        return $urandom_range(99, 0) < 37;
    endfunction

    // Send one report; the model is updated when the handshake completes.
    // valid stays up between back-to-back requests and drops only while idling.
    task automatic send_report(logic rok, logic q9, int qx, int qy, int qz,
                               logic [15:0] acc);
        while (idle_now(board.pending.size() + board.checked)) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.read_ok   <= rok;
        req_ch.has_quat9 <= q9;
        req_ch.q_x       <= qx;
        req_ch.q_y       <= qy;
        req_ch.q_z       <= qz;
        req_ch.accuracy_in <= acc;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(rok, q9, qx, qy, qz, acc);
        @(negedge i_clk);
    endtask

    // a component of a unit-ish quaternion, mostly in range, sometimes beyond
    function automatic int rand_part();
        case ($urandom_range(9, 0))
            0:       return $urandom();
            1:       return ($urandom_range(1, 0) ? ONE : -ONE);
            2:       return $urandom_range(1000, 0) - 500;
            default: return int'($urandom_range(32'h7FFFFFFF, 0) >> 1) - (ONE / 2) - 1;
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off while traffic continues
    initial begin
        rsp_ch.ready = 1'b0;
        hold_cycles = 0;
        held_once = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end else if (!held_once && board != null && board.checked == 300 &&
                         rsp_ch.valid) begin
                held_once = 1'b1;
                hold_cycles = 2000;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= idle_now(board == null ? 0 : board.checked) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            board.check_result(rsp_ch.roll_deg, rsp_ch.pitch_deg, rsp_ch.heading_deg,
                               rsp_ch.accuracy_out);
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_quaternion_to_euler_angles_core: done, errors");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        quiet_lo = 500;
        quiet_hi = 620;
        req_ch.valid = 1'b0;
        req_ch.read_ok = 1'b0;
        req_ch.has_quat9 = 1'b0;
        req_ch.q_x = '0;
        req_ch.q_y = '0;
        req_ch.q_z = '0;
        req_ch.accuracy_in = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, unusable reports, axis extremes, overrange parts
        send_report(1'b0, 1'b0, 0, 0, 0, 16'h0000);
        send_report(1'b1, 1'b1, 0, 0, 0, 16'h7FFF);                 // w = 1
        send_report(1'b1, 1'b1, ONE, 0, 0, 16'h8000);               // roll 180
        send_report(1'b1, 1'b1, -ONE, 0, 0, 16'h0001);
        send_report(1'b1, 1'b1, 0, ONE, 0, 16'hFFFF);               // roll 180, pitch 0
        send_report(1'b1, 1'b1, 0, -ONE, 0, 16'h1234);
        send_report(1'b1, 1'b1, 0, 0, ONE, 16'h4321);               // heading 0/360
        send_report(1'b1, 1'b1, 0, 0, -ONE, 16'h00FF);
        send_report(1'b0, 1'b1, 5, 6, 7, 16'h5555);                 // kept state
        send_report(1'b1, 1'b0, 5, 6, 7, 16'hAAAA);
        send_report(1'b1, 1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0F0F);
        send_report(1'b1, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hF0F0);
        send_report(1'b1, 1'b1, ONE / 2, ONE / 2, ONE / 2, 16'h0002);
        send_report(1'b1, 1'b1, -(ONE / 2), ONE / 2, -(ONE / 2), 16'h0003);
        send_report(1'b1, 1'b1, 759250125, 759250125, 0, 16'h0004);
        send_report(1'b1, 1'b1, 0, 759250125, 759250125, 16'h0005);
        send_report(1'b1, 1'b1, -1, -1, -1, 16'h0006);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if ($urandom_range(4, 0) == 0) begin
                send_report(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom(),
                            $urandom(), $urandom(), 16'($urandom()));
            end else begin
                send_report(1'b1, 1'b1, rand_part(), rand_part(), rand_part(),
                            16'($urandom()));
            end
        end
        req_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("covered %0d results, %0d quaternion updates, with a long output hold-off",
                 board.checked, board.updates);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_quaternion_to_euler_angles_core: done, clean");
        end else begin
            $display("tb_quaternion_to_euler_angles_core: done, errors");
        end
        $finish;
    end
endmodule

### files.f
sv/qte_pkg.sv
sv/qte_if.sv
sv/qte_mul.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles_core.sv
sv/qte_chk.sv
test/qte_tb_scoreboard.sv
test/tb_quaternion_to_euler_angles_core.sv
